// ----- rtl/core/oli_pkg.sv -----
// Shared constants and types for the ordered list insert engine.
package oli_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_ORDERED    = 2'd2;
    localparam logic [1:0] OP_READ_OUT   = 2'd3;

    localparam logic [1:0] STATUS_ACCEPT = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_ENTRY  = 2'd2;
    localparam logic [1:0] STATUS_EMPTY  = 2'd3;

    typedef struct packed {
        logic       insert_en;
        logic       rotate_en;
        logic [1:0] op;
    } cell_ctrl_t;

    typedef struct packed {
        logic head;
        logic valid;
        logic at_count;
        logic is_tail;
    } cell_pos_t;

endpackage

// ----- rtl/core/oli_cell.sv -----
// One storage cell of the list row: compare, insert chain and shift.
module oli_cell
(
    input  logic                               clk,
    input  oli_pkg::cell_ctrl_t                ctrl,
    input  oli_pkg::cell_pos_t                 pos,
    input  logic signed [oli_pkg::DATA_W-1:0]  new_value,
    input  logic signed [oli_pkg::DATA_W-1:0]  left_value,
    input  logic signed [oli_pkg::DATA_W-1:0]  right_value,
    input  logic signed [oli_pkg::DATA_W-1:0]  head_value,
    input  logic                               move_in,
    output logic                               move_out,
    output logic signed [oli_pkg::DATA_W-1:0]  entry_value
);

    logic signed [oli_pkg::DATA_W-1:0] entry_reg;
    logic signed [oli_pkg::DATA_W-1:0] entry_next;
    logic                              less;
    logic                              hit;

    assign less = entry_reg < new_value;

    always_comb
    begin
        case (ctrl.op)
            oli_pkg::OP_PUSH_FRONT: hit = pos.head;
            oli_pkg::OP_PUSH_BACK:  hit = pos.at_count;
            oli_pkg::OP_ORDERED:    hit = (pos.valid && !less) || pos.at_count;
            default:                hit = 1'b0;
        endcase
    end

    assign move_out = hit || move_in;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en)
        begin
            if (move_out && !move_in)
            begin
                entry_next = new_value;
            end
            else if (move_out && (pos.valid || pos.at_count))
            begin
                entry_next = left_value;
            end
        end
        else if (ctrl.rotate_en)
        begin
            if (pos.is_tail)
            begin
                entry_next = head_value;
            end
            else if (pos.valid)
            begin
                entry_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_value = entry_reg;

endmodule

// ----- rtl/core/ordered_list_insert_engine_unit.sv -----
// Top level of the ordered list insert engine: control and the row of cells.
//
// Input stream s_axis: tuser carries op, tdata carries the signed value.
// Output stream m_axis: tdata carries entry_value, tuser the status, tlast
// marks the final result of a request.
// For push-front, push-back and ordered insert the result is registered in
// the output register, and a new request is taken in the same cycle the
// previous result leaves. An insert into a full list is dropped and
// answered with status full. On read-out the cell row rotates toward the
// head once per entry and the head cell is emitted, so after the last entry
// the list is back in order. Input stays stalled until the tail entry has
// gone into the output register. Reading an empty list gives one result
// with status empty. Reset clears the entry count and the control state;
// cell contents are not cleared. When the receiver stalls, the output
// register holds its result and both the read-out sequence and the input
// wait.
module ordered_list_insert_engine_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,   // value[31:0]
    input  logic [1:0]                 s_axis_tuser,   // op[1:0]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,   // entry_value[31:0]
    output logic [1:0]                 m_axis_tuser,   // status[1:0]
    output logic                       m_axis_tlast    // last
);

    typedef enum logic [0:0] {ST_IDLE, ST_READ} state_t;

    state_t                        state_reg, state_next;
    logic [oli_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [oli_pkg::CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                          out_valid_reg, out_valid_next;
    logic [oli_pkg::DATA_W-1:0]    out_data_reg, out_data_next;
    logic [1:0]                    out_status_reg, out_status_next;
    logic                          out_last_reg, out_last_next;

    oli_pkg::cell_ctrl_t           ctrl;
    logic                          out_free;
    logic                          accept;
    logic                          rd_last;
    logic signed [oli_pkg::DATA_W-1:0] cell_value [oli_pkg::CAPACITY];
    logic [oli_pkg::CAPACITY:0]    move;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rd_last       = oli_pkg::CNT_W'(rd_idx_reg + oli_pkg::CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ctrl.insert_en  = 1'b0;
        ctrl.rotate_en  = 1'b0;
        ctrl.op         = s_axis_tuser;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == oli_pkg::OP_READ_OUT)
                    begin
                        if (count_reg == '0)
                        begin
                            out_valid_next  = 1'b1;
                            out_data_next   = '0;
                            out_status_next = oli_pkg::STATUS_EMPTY;
                            out_last_next   = 1'b1;
                        end
                        else
                        begin
                            state_next  = ST_READ;
                            rd_idx_next = '0;
                        end
                    end
                    else if (count_reg == oli_pkg::CNT_W'(oli_pkg::CAPACITY))
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = '0;
                        out_status_next = oli_pkg::STATUS_FULL;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert_en  = 1'b1;
                        count_next      = oli_pkg::CNT_W'(count_reg + oli_pkg::CNT_W'(1));
                        out_valid_next  = 1'b1;
                        out_data_next   = '0;
                        out_status_next = oli_pkg::STATUS_ACCEPT;
                        out_last_next   = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                ctrl.op = oli_pkg::OP_READ_OUT;
                if (out_free)
                begin
                    ctrl.rotate_en  = 1'b1;
                    out_valid_next  = 1'b1;
                    out_data_next   = cell_value[0];
                    out_status_next = oli_pkg::STATUS_ENTRY;
                    out_last_next   = rd_last;
                    rd_idx_next     = oli_pkg::CNT_W'(rd_idx_reg + oli_pkg::CNT_W'(1));
                    if (rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign move[0] = 1'b0;

    for (genvar i = 0; i < oli_pkg::CAPACITY; i++)
    begin : g_cell
        oli_pkg::cell_pos_t                pos;
        logic signed [oli_pkg::DATA_W-1:0] left_value;
        logic signed [oli_pkg::DATA_W-1:0] right_value;

        assign pos.head     = (i == 0);
        assign pos.valid    = oli_pkg::CNT_W'(i) < count_reg;
        assign pos.at_count = oli_pkg::CNT_W'(i) == count_reg;
        assign pos.is_tail  = oli_pkg::CNT_W'(i + 1) == count_reg;

        if (i == 0)
        begin : g_left_head
            assign left_value = s_axis_tdata;
        end
        else
        begin : g_left_cell
            assign left_value = cell_value[i-1];
        end

        if (i == oli_pkg::CAPACITY - 1)
        begin : g_right_end
            assign right_value = cell_value[0];
        end
        else
        begin : g_right_cell
            assign right_value = cell_value[i+1];
        end

        oli_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .pos         (pos),
            .new_value   (s_axis_tdata),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .move_in     (move[i]),
            .move_out    (move[i+1]),
            .entry_value (cell_value[i])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- dv/tb_ordered_list_insert_engine_unit.sv -----
// Testbench for the ordered list insert engine: directed and random requests.
`timescale 1ns / 1ps

module tb_ordered_list_insert_engine_unit;

    typedef struct packed {
        logic [oli_pkg::DATA_W-1:0] entry_value;
        logic [1:0]                 status;
        logic                       last;
    } list_result_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;     // value[31:0]
    logic [1:0]        s_axis_tuser  = oli_pkg::OP_READ_OUT;  // op[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;           // entry_value[31:0]
    logic [1:0]        m_axis_tuser;           // status[1:0]
    logic              m_axis_tlast;

    logic signed [oli_pkg::DATA_W-1:0] list_model [oli_pkg::CAPACITY];
    int                                list_count     = 0;
    list_result_t                      pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int full_drops     = 0;
    int readouts_done  = 0;

    ordered_list_insert_engine_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic void apply_list_request(input logic [1:0] op,
                                               input logic signed [oli_pkg::DATA_W-1:0] value);
        int pos;
        int i;
        if (op == oli_pkg::OP_READ_OUT)
        begin
            readouts_done++;
            if (list_count == 0)
                pending_results.push_back('{'0, oli_pkg::STATUS_EMPTY, 1'b1});
            for (i = 0; i < list_count; i++)
                pending_results.push_back('{list_model[i], oli_pkg::STATUS_ENTRY,
                                            (i == list_count - 1)});
            return;
        end
        if (list_count >= oli_pkg::CAPACITY)
        begin
            full_drops++;
            pending_results.push_back('{'0, oli_pkg::STATUS_FULL, 1'b1});
            return;
        end
        pos = list_count;
        if (op == oli_pkg::OP_PUSH_FRONT)
            pos = 0;
        else if (op == oli_pkg::OP_ORDERED)
        begin
            for (i = 0; i < list_count; i++)
            begin
                if (!(list_model[i] < value))
                begin
                    pos = i;
                    break;
                end
            end
        end
        for (i = list_count; i > pos; i--)
            list_model[i] = list_model[i-1];
        list_model[pos] = value;
        list_count++;
        pending_results.push_back('{'0, oli_pkg::STATUS_ACCEPT, 1'b1});
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
        apply_list_request(op, value);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (oli_pkg::CAPACITY + 4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: entry_value %0d status %0d last %0d",
                       $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.entry_value)
                begin
                    $error("entry_value: expected %0d, got %0d",
                           $signed(want.entry_value), $signed(m_axis_tdata));
                    error_count++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_empty_list();
        send_request(oli_pkg::OP_READ_OUT, $urandom());
        send_request(oli_pkg::OP_ORDERED, 32'd123);
        send_request(oli_pkg::OP_READ_OUT, 32'hFFFF_FFFF);
        wait_for_drain();
    endtask

    task automatic test_insert_ops();
        send_request(oli_pkg::OP_PUSH_BACK, 32'd0);
        send_request(oli_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_request(oli_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(oli_pkg::OP_ORDERED, 32'hFFFF_FFFF);
        send_request(oli_pkg::OP_ORDERED, 32'd0);
        send_request(oli_pkg::OP_ORDERED, 32'h8000_0000);
        send_request(oli_pkg::OP_ORDERED, 32'h7FFF_FFFF);
        send_request(oli_pkg::OP_ORDERED, 32'd5);
        send_request(oli_pkg::OP_ORDERED, 32'd123);
        send_request(oli_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(oli_pkg::OP_PUSH_BACK, 32'h8000_0000);
        send_request(oli_pkg::OP_ORDERED, 32'h5555_5555);
        send_request(oli_pkg::OP_ORDERED, 32'hAAAA_AAAA);
        send_request(oli_pkg::OP_READ_OUT, 32'd0);
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int count);
        logic [1:0]  op;
        logic [31:0] value;
        int          n;
        for (n = 0; n < count; n++)
        begin
            case ($urandom_range(9)) inside
                [0:3]:   op = oli_pkg::OP_ORDERED;
                [4:5]:   op = oli_pkg::OP_PUSH_FRONT;
                [6:7]:   op = oli_pkg::OP_PUSH_BACK;
                default: op = oli_pkg::OP_READ_OUT;
            endcase
            case ($urandom_range(7))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = 32'hFFFF_FFFF;
                3:       value = (list_count > 0) ?
                                 list_model[$urandom_range(list_count - 1)] : 32'd0;
                default: value = $urandom();
            endcase
            send_request(op, value);
        end
        wait_for_drain();
    endtask

    initial
    begin
        send_idle_pct  = 16;
        recv_stall_pct = 66;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_insert_ops();
        test_random_traffic(30);
        send_idle_pct  = 66;
        recv_stall_pct = 16;
        test_random_traffic(28);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(28);
        $display("Sent %0d requests (%0d read-outs, %0d inserts dropped on a full list),",
                 requests_sent, readouts_done, full_drops);
        $display("checked %0d results; final list holds %0d entries.",
                 results_seen, list_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
